FILE: hw/rtl/dtfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfd_pkg
// Shared types, constants and character tables for the double to fixed
// decimal text formatter.
// ----------------------------------------------------------------------------
package dtfd_pkg;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [10:0] EXP_TINY_MIN = 11'd1012;  // biased exponent of -11
  localparam logic [10:0] EXP_BIG_MAX  = 11'd1054;  // biased exponent of 31
  localparam logic [10:0] EXP_SHIFT_BASE = 11'd1011;

  localparam logic [2:0] PREC_RESET = 3'd6;
  localparam logic [2:0] PREC_MAX   = 3'd6;
  localparam logic [2:0] PREC_ILLEGAL = 3'd7;

  localparam logic [3:0] INT_TOP_IDX = 4'd9;

  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_POINT = 7'h2E;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;

  localparam logic [23:0] STR_NAN = "nan";
  localparam logic [23:0] STR_INF = "inf";
  localparam logic [63:0] STR_OVF = "overflow";

  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_NAN,
    KIND_INF,
    KIND_OVF
  } kind_e;

  typedef enum logic [2:0] {
    SRC_SIGN,
    SRC_TEXT,
    SRC_INT,
    SRC_POINT,
    SRC_FDIG
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_FRAC,
    ST_ROUND,
    ST_SIGN,
    ST_INT,
    ST_POINT,
    ST_FDIG
  } state_e;

  typedef struct packed {
    logic       load;
    logic       frac_step;
    logic       round;
    logic       int_step;
    logic       emit;
    src_e       src;
    logic       last;
    logic [3:0] idx;
  } cmd_t;

  typedef struct packed {
    kind_e      kind;
    logic       sign;
    logic [2:0] prec;
    logic       int_zero;
    logic       out_free;
  } sts_t;

  function automatic logic [33:0] pow10(logic [3:0] k);
    logic [33:0] p;
    p = 34'd1;
    case (k)
      4'd0: p = 34'd1;
      4'd1: p = 34'd10;
      4'd2: p = 34'd100;
      4'd3: p = 34'd1000;
      4'd4: p = 34'd10000;
      4'd5: p = 34'd100000;
      4'd6: p = 34'd1000000;
      4'd7: p = 34'd10000000;
      4'd8: p = 34'd100000000;
      4'd9: p = 34'd1000000000;
      default: p = 34'd1;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] text_len(kind_e k);
    logic [3:0] n;
    n = 4'd3;
    case (k)
      KIND_OVF: n = 4'd8;
      default: n = 4'd3;
    endcase
    return n;
  endfunction

  function automatic logic [6:0] text_char(kind_e k, logic [3:0] i);
    logic [63:0] s;
    s = 64'h0;
    case (k)
      KIND_NAN: s = {STR_NAN, 40'h0};
      KIND_INF: s = {STR_INF, 40'h0};
      KIND_OVF: s = STR_OVF;
      default: s = 64'h0;
    endcase
    s = s << {i[2:0], 3'b000};
    return s[62:56];
  endfunction

endpackage

FILE: hw/rtl/double_to_fixed_decimal_text_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_to_fixed_decimal_text_top
// Formats the bit pattern of a double as fixed-point decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, value_bits_i) takes one 64-bit
//   double per request while the block is idle. Output channel
//   (out_valid_o/out_ready_i) delivers the text one character per request,
//   last_char_o marking the final character. Config channel
//   (cfg_valid_i/cfg_ready_o, fraction_digits_i) sets digits after the
//   point, 0 to 6 (7 acts as 6); write it only while idle. Reset value 6.
// Sequence:
//   The sequencer classifies the value; for values in the printable range
//   it then generates the fraction digits by multiply-by-ten, one past the
//   precision, and rounds them. Characters then leave at one per cycle
//   while the receiver is ready, and each suppressed leading integer zero
//   (up to nine) occupies the sequencer without emitting a character. The
//   next value is accepted only once the sequencer is idle again, since the
//   digit units and the single output register are shared.
// Reset clears the sequencer and the output valid flag; a stalled receiver
// holds the current character and pauses the sequencer at its next character.
// ----------------------------------------------------------------------------
module double_to_fixed_decimal_text_top
  import dtfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  text_char_o,
  output logic        last_char_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  fraction_digits_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  dtfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dtfd_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .value_bits_i      (value_bits_i),
    .cfg_valid_i       (cfg_valid_i),
    .fraction_digits_i (fraction_digits_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .text_char_o       (text_char_o),
    .last_char_o       (last_char_o)
  );

endmodule

FILE: hw/rtl/dtfd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfd_datapath
// Operand registers, fraction digit generator, rounding, integer digit
// extraction and the output character register.
// ----------------------------------------------------------------------------
module dtfd_datapath
  import dtfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] value_bits_i,
  input  logic        cfg_valid_i,
  input  logic [2:0]  fraction_digits_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  text_char_o,
  output logic        last_char_o
);

  logic [2:0]  cfg_q;
  kind_e       kind_q;
  logic        sign_q;
  logic [2:0]  prec_q;
  logic [31:0] v_q;
  logic [63:0] f_q;
  logic [3:0]  d_q [7];
  logic        rnd_q;
  logic        out_valid_q;
  logic [6:0]  text_q;
  logic        last_q;

  logic [10:0]  ebits;
  logic [52:0]  mant;
  logic [5:0]   sh;
  logic [116:0] x;
  kind_e        kind_d;
  logic         zero_d;
  logic [67:0]  prod;
  logic [33:0]  p;
  logic [3:0]   int_dig;
  logic [35:0]  int_sub;
  logic [3:0]   nd [7];
  logic         carry;
  logic         fire;
  logic [6:0]   char_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= PREC_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= fraction_digits_i;
    end
  end

  always_comb begin
    ebits = value_bits_i[62:52];
    mant  = {1'b1, value_bits_i[51:0]};
    sh    = 6'(ebits - EXP_SHIFT_BASE);
    x     = {64'h0, mant} << sh;
    zero_d = 1'b0;
    if (ebits == EXP_ALL_ONES) begin
      kind_d = (value_bits_i[51:0] != 52'h0) ? KIND_NAN : KIND_INF;
    end else if (ebits > EXP_BIG_MAX) begin
      kind_d = KIND_OVF;
    end else begin
      kind_d = KIND_NUM;
      zero_d = (ebits < EXP_TINY_MIN);
    end
  end

  always_comb begin
    prod = ({4'h0, f_q} << 3) + ({4'h0, f_q} << 1);
  end

  always_comb begin
    p = pow10(cmd_i.idx);
    int_dig = 4'd0;
    int_sub = 36'd0;
    for (int c = 1; c <= 9; c++) begin
      if ({4'h0, v_q} >= 36'(c) * {2'b00, p}) begin
        int_dig = 4'(c);
        int_sub = 36'(c) * {2'b00, p};
      end
    end
  end

  always_comb begin
    carry = rnd_q;
    for (int i = 6; i >= 0; i--) begin
      nd[i] = d_q[i];
      if ((3'(i) < prec_q) && carry) begin
        if (d_q[i] == 4'd9) begin
          nd[i] = 4'd0;
        end else begin
          nd[i] = d_q[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_d;
      sign_q <= value_bits_i[63];
      prec_q <= (cfg_q == PREC_ILLEGAL) ? PREC_MAX : cfg_q;
      if (zero_d) begin
        v_q <= 32'h0;
        f_q <= 64'h0;
      end else begin
        v_q <= x[95:64];
        f_q <= x[63:0];
      end
    end else if (cmd_i.frac_step) begin
      f_q <= prod[63:0];
      if (cmd_i.idx[2:0] == prec_q) begin
        rnd_q <= (prod[67:64] >= 4'd5);
      end else begin
        d_q[cmd_i.idx[2:0]] <= prod[67:64];
      end
    end else if (cmd_i.round) begin
      for (int i = 0; i < 7; i++) begin
        d_q[i] <= nd[i];
      end
      v_q <= v_q + 32'(carry);
    end else if (cmd_i.int_step) begin
      v_q <= v_q - int_sub[31:0];
    end
  end

  always_comb begin
    char_d = CHAR_MINUS;
    case (cmd_i.src)
      SRC_SIGN:  char_d = CHAR_MINUS;
      SRC_POINT: char_d = CHAR_POINT;
      SRC_INT:   char_d = CHAR_ZERO | {3'b000, int_dig};
      SRC_FDIG:  char_d = CHAR_ZERO | {3'b000, d_q[cmd_i.idx[2:0]]};
      SRC_TEXT:  char_d = text_char(kind_q, cmd_i.idx);
      default:   char_d = CHAR_MINUS;
    endcase
  end

  assign fire = cmd_i.emit && sts_o.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      text_q <= char_d;
      last_q <= cmd_i.last;
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.sign     = sign_q;
  assign sts_o.prec     = prec_q;
  assign sts_o.int_zero = (int_dig == 4'd0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign text_char_o = text_q;
  assign last_char_o = last_q;

`ifndef SYNTH
  a_frac_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.frac_step |-> prod[67:64] <= 4'd9)
    else $error("fraction digit out of range");
  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("emitted character not presented");
  a_int_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.int_step |-> int_sub <= {4'h0, v_q})
    else $error("integer digit subtract underflow");
`endif

endmodule

FILE: hw/rtl/dtfd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfd_ctrl
// Sequencer: classifies the value, steps fraction digit generation and
// rounding, then walks the character sequence one request at a time.
// ----------------------------------------------------------------------------
module dtfd_ctrl
  import dtfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [3:0] idx_q, idx_d;
  logic       started_q, started_d;
  logic       text_q, text_d;
  logic       fire;
  logic       advance;
  logic [3:0] prec_w;

  assign prec_w = {1'b0, sts_i.prec};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= 4'd0;
      started_q <= 1'b0;
      text_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      started_q <= started_d;
      text_q    <= text_d;
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.src = SRC_SIGN;
    cmd_o.idx = idx_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !text_q;
        if (text_q) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_TEXT;
          cmd_o.last = (idx_q == text_len(sts_i.kind) - 4'd1);
        end else begin
          cmd_o.load = in_valid_i;
        end
      end
      ST_FRAC: cmd_o.frac_step = 1'b1;
      ST_ROUND: cmd_o.round = 1'b1;
      ST_SIGN: begin
        cmd_o.emit = 1'b1;
        cmd_o.src  = SRC_SIGN;
      end
      ST_INT: begin
        cmd_o.emit = started_q || !sts_i.int_zero || (idx_q == 4'd0);
        cmd_o.src  = SRC_INT;
        cmd_o.last = (idx_q == 4'd0) && (sts_i.prec == 3'd0);
      end
      ST_POINT: begin
        cmd_o.emit = 1'b1;
        cmd_o.src  = SRC_POINT;
      end
      ST_FDIG: begin
        cmd_o.emit = 1'b1;
        cmd_o.src  = SRC_FDIG;
        cmd_o.last = (idx_q == prec_w - 4'd1);
      end
      default: cmd_o = '0;
    endcase
    cmd_o.int_step = (state_q == ST_INT) && (cmd_o.emit ? sts_i.out_free : 1'b1);
  end

  assign fire    = cmd_o.emit && sts_i.out_free;
  assign advance = cmd_o.int_step;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    started_d = started_q;
    text_d    = text_q;
    case (state_q)
      ST_IDLE: begin
        if (text_q) begin
          if (fire) begin
            if (idx_q == text_len(sts_i.kind) - 4'd1) begin
              text_d = 1'b0;
              idx_d  = 4'd0;
            end else begin
              idx_d = idx_q + 4'd1;
            end
          end
        end else if (in_valid_i) begin
          state_d   = ST_CLASS;
          idx_d     = 4'd0;
          started_d = 1'b0;
        end
      end
      ST_CLASS: begin
        idx_d = 4'd0;
        case (sts_i.kind)
          KIND_NUM: state_d = ST_FRAC;
          KIND_NAN: begin
            state_d = ST_IDLE;
            text_d  = 1'b1;
          end
          default: begin
            if (sts_i.sign) begin
              state_d = ST_SIGN;
            end else begin
              state_d = ST_IDLE;
              text_d  = 1'b1;
            end
          end
        endcase
      end
      ST_FRAC: begin
        if (idx_q == prec_w) begin
          state_d = ST_ROUND;
          idx_d   = 4'd0;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      ST_ROUND: begin
        state_d = sts_i.sign ? ST_SIGN : ST_INT;
        idx_d   = INT_TOP_IDX;
      end
      ST_SIGN: begin
        if (fire) begin
          if (sts_i.kind == KIND_NUM) begin
            state_d = ST_INT;
            idx_d   = INT_TOP_IDX;
          end else begin
            state_d = ST_IDLE;
            text_d  = 1'b1;
            idx_d   = 4'd0;
          end
        end
      end
      ST_INT: begin
        if (fire) begin
          started_d = 1'b1;
        end
        if (advance) begin
          if (idx_q == 4'd0) begin
            state_d = (sts_i.prec == 3'd0) ? ST_IDLE : ST_POINT;
          end else begin
            idx_d = idx_q - 4'd1;
          end
        end
      end
      ST_POINT: begin
        if (fire) begin
          state_d = ST_FDIG;
          idx_d   = 4'd0;
        end
      end
      ST_FDIG: begin
        if (fire) begin
          if (idx_q == prec_w - 4'd1) begin
            state_d = ST_IDLE;
            idx_d   = 4'd0;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_load_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_CLASS)
    else $error("accepted request not classified");
  a_fdig_prec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FDIG |-> sts_i.prec != 3'd0)
    else $error("fraction digits emitted with zero precision");
  a_frac_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FRAC |-> idx_q <= prec_w)
    else $error("fraction step index past precision");
  a_text_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_q |-> state_q == ST_IDLE && !in_ready_o)
    else $error("text walk outside idle");
`endif

endmodule

FILE: verif/double_to_fixed_decimal_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_to_fixed_decimal_text_checker
// Watches the value, text and digit-count channels of the formatter, builds
// the expected text of every accepted value and compares each character and
// its last flag against it in order.
// ----------------------------------------------------------------------------
module double_to_fixed_decimal_text_checker
  import dtfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] value_bits_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [6:0]  text_char_i,
  input  logic        last_char_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  fraction_digits_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [6:0]  ch;
    logic        last;
    logic [63:0] bits;
  } text_char_t;

  text_char_t expected_text [$];
  logic [2:0] digits;

  function automatic string format_double(input logic [63:0] bits, input logic [2:0] cfg);
    logic        neg;
    logic [10:0] ebits;
    logic [51:0] frac;
    logic [2:0]  prec;
    int          fb;
    logic [52:0] mant;
    logic [31:0] ipart;
    logic [67:0] rem;
    logic [67:0] prod;
    logic [67:0] mask;
    logic [3:0]  dig [0:6];
    int          k;
    string       s;
    neg   = bits[63];
    ebits = bits[62:52];
    frac  = bits[51:0];
    prec  = (cfg > PREC_MAX) ? PREC_MAX : cfg;
    s     = "";
    if (ebits == EXP_ALL_ONES) begin
      if (frac != '0) s = "nan";
      else s = neg ? "-inf" : "inf";
      return s;
    end
    if (neg) s = "-";
    if (ebits < EXP_TINY_MIN) begin
      s = {s, "0"};
      if (prec != 0) s = {s, "."};
      for (k = 0; k < prec; k++) s = {s, "0"};
    end else if (ebits > EXP_BIG_MAX) begin
      s = {s, "overflow"};
    end else begin
      fb    = 52 - (int'(ebits) - 1023);
      mant  = {1'b1, frac};
      ipart = 32'(mant >> fb);
      mask  = (68'd1 << fb) - 68'd1;
      rem   = 68'(mant) & mask;
      for (k = 0; k <= prec; k++) begin
        prod   = rem * 68'd10;
        dig[k] = 4'(prod >> fb);
        rem    = prod & mask;
      end
      if (dig[prec] >= 4'd5) begin
        k = int'(prec) - 1;
        while (k >= 0 && dig[k] == 4'd9) begin
          dig[k] = 4'd0;
          k--;
        end
        if (k >= 0) dig[k] = dig[k] + 4'd1;
        else ipart = ipart + 32'd1;
      end
      s = {s, $sformatf("%0d", ipart)};
      if (prec != 0) s = {s, "."};
      for (k = 0; k < prec; k++) s = {s, $sformatf("%0d", dig[k])};
    end
    return s;
  endfunction

  always @(posedge clk_i) begin
    text_char_t head;
    text_char_t item;
    string      s;
    byte        b;
    if (!rst_ni) begin
      digits = PREC_RESET;
      expected_text.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) digits = fraction_digits_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_text.size() == 0) begin
          if (fail_count_o < 10)
            $display("text mismatch: nothing expected, got char %h last %b",
                     text_char_i, last_char_i);
          fail_count_o++;
        end else begin
          head = expected_text.pop_front();
          if (head.ch !== text_char_i || head.last !== last_char_i) begin
            if (fail_count_o < 10)
              $display("text mismatch: value %h expected char %h last %b, got char %h last %b",
                       head.bits, head.ch, head.last, text_char_i, last_char_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        s = format_double(value_bits_i, digits);
        for (int i = 0; i < s.len(); i++) begin
          b         = s[i];
          item.ch   = b[6:0];
          item.last = (i == s.len() - 1);
          item.bits = value_bits_i;
          expected_text.push_back(item);
        end
      end
    end
    pending_o = expected_text.size();
  end

endmodule

FILE: verif/tb_double_to_fixed_decimal_text_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_to_fixed_decimal_text_top
// Drives double bit patterns and digit-count settings into the formatter:
// edge values first, then random values biased toward printable exponents and
// rounding carries, under random idling on both channels. The checker
// predicts every text character; a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb_double_to_fixed_decimal_text_top;
  import dtfd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 40;

  localparam logic [63:0] EDGE_VALUES [22] = '{
    64'h0000000000000000, 64'h8000000000000000, 64'h7FF8000000000000,
    64'hFFFFFFFFFFFFFFFF, 64'h7FF0000000000000, 64'hFFF0000000000000,
    64'h3FF0000000000000, 64'hC004000000000000, 64'h41E0000000000000,
    64'h41EFFFFFFFFFFFFF, 64'hC1EFFFFFFFFFFFFF, 64'h41F0000000000000,
    64'hFFEFFFFFFFFFFFFF, 64'h000FFFFFFFFFFFFF, 64'h0010000000000000,
    64'h3F40000000000000, 64'h3F3FFFFFFFFFFFFF, 64'h3FB999999999999A,
    64'h3FE0000000000000, 64'h3FEFFFFFFFFFFFFF, 64'h408F3FFFFFFFFFFF,
    64'h40FE240C9FBE76C9
  };

  localparam logic [2:0] DIGIT_PLAN [8] = '{
    3'd0, PREC_ILLEGAL, 3'd3, 3'd1, 3'd5, 3'd2, 3'd4, PREC_MAX
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] value_bits_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [6:0]  text_char_o;
  logic        last_char_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  fraction_digits_i = '0;

  logic        idling = 1'b0;
  int          stall_left = 0;
  int          quiet = 0;
  int          fail_count;
  int          pending;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  double_to_fixed_decimal_text_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .value_bits_i      (value_bits_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .text_char_o       (text_char_o),
    .last_char_o       (last_char_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .fraction_digits_i (fraction_digits_i)
  );

  double_to_fixed_decimal_text_checker text_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .value_bits_i      (value_bits_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .text_char_i       (text_char_o),
    .last_char_i       (last_char_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .fraction_digits_i (fraction_digits_i),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 13);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("tb_double_to_fixed_decimal_text_top: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [63:0] random_double();
    logic [63:0] v;
    logic [51:0] carry_mask;
    int          pick;
    v    = {$urandom, $urandom};
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      v[62:52] = 11'($urandom_range(1012, 1054));
    end else if (pick < 15) begin
      v[62:52]   = 11'($urandom_range(1012, 1054));
      carry_mask = (v[62:52] > 11'd1023) ? (52'hFFFFFFFFFFFFF >> (v[62:52] - 11'd1023))
                                         : 52'hFFFFFFFFFFFFF;
      v[51:0]    = v[51:0] | (carry_mask & ~52'hFFFFF);
    end else if (pick == 15) begin
      v[62:52] = EXP_ALL_ONES;
      if ($urandom_range(0, 1) == 0) v[51:0] = '0;
    end else if (pick == 16) begin
      v[62:52] = 11'($urandom_range(0, 1011));
    end else if (pick == 17) begin
      v[62:52] = 11'($urandom_range(1055, 2046));
    end
    return v;
  endfunction

  task automatic send_value(input logic [63:0] bits);
    int gap;
    if (idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    value_bits_i <= bits;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_digits(input logic [2:0] count);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    fraction_digits_i <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    idling <= 1'b1;
    @(posedge clk_i);
    foreach (EDGE_VALUES[i]) send_value(EDGE_VALUES[i]);
    repeat (PHASE_ITEMS) send_value(random_double());
    for (int p = 0; p < 8; p++) begin
      write_digits(DIGIT_PLAN[p]);
      idling <= !(p == 3 || p == 7);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 20) wait_drained();
        send_value(random_double());
      end
    end
    wait_drained();
    repeat (64) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_double_to_fixed_decimal_text_top: PASS");
    end else begin
      $display("tb_double_to_fixed_decimal_text_top: FAIL");
    end
    $finish;
  end

endmodule
